### rtl/polyline_step_resampler_defines.svh
// Assertion macros for the polyline step resampler.
// Used by the top level; expects clk and arst_n in scope.
`ifndef POLYLINE_STEP_RESAMPLER_DEFINES_SVH
`define POLYLINE_STEP_RESAMPLER_DEFINES_SVH

// same-cycle implication, off during reset
`define PSR_ASSERT_NOW(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

// next-cycle implication, off during reset
`define PSR_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

### rtl/psr_pkg.sv
// Shared types, constants and states for the polyline step resampler.
// No dependencies.
package psr_pkg;

	localparam int FRAC_BITS           = 16;
	localparam int MAX_PER_SEGMENT_DEF = 63;
	localparam int ADDR_W              = 3;
	localparam int STEP_W              = 31;
	localparam int THR_W               = 16;

	localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(1) << FRAC_BITS;
	localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(1);

	// register index, taken from paddr[2]
	localparam logic REG_STEP_LENGTH   = 1'b0;
	localparam logic REG_DUP_THRESHOLD = 1'b1;

	// one vertex request as handed from front to back
	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] px;
		logic [31:0] py;
		logic        fin;
		logic        first;
	} vtx_t;

	// one result request
	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic        run_end;
		logic        trunc;
	} res_t;

	typedef struct packed {
		logic        start;
		logic [32:0] num_hi;
		logic [32:0] num_lo;
		logic [32:0] den;
	} div_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [32:0] quot;
		logic [32:0] rem;
	} div_rsp_t;

	typedef struct packed {
		logic        start;
		logic [65:0] rad;
	} sqrt_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [32:0] root;
	} sqrt_rsp_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_FIRST, ST_SQX, ST_SQY, ST_SUM, ST_SQRT, ST_CMP, ST_DIVN,
		ST_MULX, ST_DXS, ST_DIVX, ST_MULY, ST_DYS, ST_DIVY, ST_EMIT,
		ST_FX, ST_FY, ST_FT, ST_FC, ST_FLUSH
	} back_state_t;

endpackage

### rtl/psr_fifo.sv
// Small register queue, used between front and back and at the output.
// Depends on nothing.
module psr_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             full,
	output logic             empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_q, rd_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push, do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (do_pop)
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= din;
	end

endmodule

### rtl/psr_sqrt.sv
// Iterative integer square root, two radicand bits per cycle.
// Depends on psr_pkg.
module psr_sqrt (
	input  logic               clk,
	input  logic               arst_n,
	input  psr_pkg::sqrt_req_t req,
	output psr_pkg::sqrt_rsp_t rsp
);
	import psr_pkg::*;

	logic [65:0] rad_q;
	logic [35:0] rem_q;
	logic [32:0] root_q;
	logic [5:0]  cnt_q;
	logic        busy_q, done_q;
	logic [35:0] r2, trial;
	logic        ge;

	assign r2    = {rem_q[33:0], rad_q[65:64]};
	assign trial = {1'b0, root_q, 2'b01};
	assign ge    = (r2 >= trial);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// restoring digit recurrence
	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			rad_q  <= req.rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[63:0], 2'b00};
			rem_q  <= ge ? r2 - trial : r2;
			root_q <= {root_q[31:0], ge};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.root = root_q;

endmodule

### rtl/psr_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on psr_pkg. The high numerator part must be below the divisor.
module psr_div (
	input  logic              clk,
	input  logic              arst_n,
	input  psr_pkg::div_req_t req,
	output psr_pkg::div_rsp_t rsp
);
	import psr_pkg::*;

	logic [32:0] rem_q, lo_q, den_q;
	logic [5:0]  cnt_q;
	logic        busy_q, done_q;
	logic [33:0] t, diff;
	logic        ge;

	assign t    = {rem_q, lo_q[32]};
	assign diff = t - {1'b0, den_q};
	assign ge   = (t >= {1'b0, den_q});

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift-subtract
	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			rem_q <= req.num_hi;
			lo_q  <= req.num_lo;
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[32:0] : t[32:0];
			lo_q  <= {lo_q[31:0], ge};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = lo_q;
	assign rsp.rem  = rem_q;

endmodule

### rtl/psr_front.sv
// Front end: accepts vertices, tracks the previous vertex and the polyline
// start, and queues classified requests. Depends on psr_pkg.
module psr_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  logic [31:0]   vertex_x,
	input  logic [31:0]   vertex_y,
	input  logic          final_vertex,
	output logic          q_push,
	output psr_pkg::vtx_t q_din,
	input  logic          q_full
);
	import psr_pkg::*;

	vtx_t        req_s1;
	logic        v_s1;
	logic [31:0] prev_x_q, prev_y_q;
	logic        awaiting_q;
	logic        accept;

	assign full   = v_s1 && q_full;
	assign accept = push && !full;
	assign q_push = v_s1 && !q_full;
	assign q_din  = req_s1;

	// polyline tracking: after a final vertex the next one starts anew
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			awaiting_q <= 1'b1;
			prev_x_q   <= '0;
			prev_y_q   <= '0;
		end else begin
			if (accept) begin
				v_s1       <= 1'b1;
				awaiting_q <= final_vertex;
				prev_x_q   <= vertex_x;
				prev_y_q   <= vertex_y;
			end else if (q_push) begin
				v_s1 <= 1'b0;
			end
		end
	end

	// classified request
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1.x     <= vertex_x;
			req_s1.y     <= vertex_y;
			req_s1.px    <= prev_x_q;
			req_s1.py    <= prev_y_q;
			req_s1.fin   <= final_vertex;
			req_s1.first <= awaiting_q;
		end
	end

endmodule

### rtl/psr_back.sv
// Back end: segment length, step count and interpolated points, one
// vertex at a time, with a hold register that settles run_end.
// Depends on psr_pkg; drives the square root and divider units.
module psr_back #(
	parameter int MAX_PER_SEGMENT = psr_pkg::MAX_PER_SEGMENT_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [psr_pkg::STEP_W-1:0] step_length,
	input  logic [psr_pkg::THR_W-1:0]  dup_threshold,
	input  logic                      q_empty,
	input  psr_pkg::vtx_t             q_dout,
	output logic                      q_pop,
	output psr_pkg::sqrt_req_t        sqrt_req,
	input  psr_pkg::sqrt_rsp_t        sqrt_rsp,
	output psr_pkg::div_req_t         div_req,
	input  psr_pkg::div_rsp_t         div_rsp,
	output logic                      out_push,
	output psr_pkg::res_t             out_din,
	input  logic                      out_full
);
	import psr_pkg::*;

	localparam int CW = $clog2(MAX_PER_SEGMENT + 1);

	back_state_t state_q, state_d;

	vtx_t        cur_q;
	logic [64:0] mul_q;
	logic [65:0] acc_q;
	logic [32:0] len_q, pos_q, posn_q, p_q;
	logic [CW-1:0] cnt_q, lim_q;
	logic        trunc_q;
	logic [31:0] qx_q, qy_q;
	logic [31:0] last_x_q, last_y_q;
	res_t        hold_q;
	logic        hold_v_q;

	logic [STEP_W-1:0] step_eff;
	logic [32:0] dx, dy, ex, ey;
	logic [31:0] adx, ady, aex, aey;
	logic [32:0] mul_a;
	logic [31:0] mul_b;
	logic        mul_en;
	logic        emit_req, emit_ok;
	logic [31:0] emit_x, emit_y;
	logic        emit_tr;
	logic [33:0] n_cnt;
	logic        n_over;
	logic        seg_last;
	logic [31:0] pt_x, pt_y;

	assign step_eff = (step_length == '0) ? STEP_W'(1) : step_length;

	// differences and magnitudes
	assign dx  = {cur_q.x[31], cur_q.x} - {cur_q.px[31], cur_q.px};
	assign dy  = {cur_q.y[31], cur_q.y} - {cur_q.py[31], cur_q.py};
	assign ex  = {cur_q.x[31], cur_q.x} - {last_x_q[31], last_x_q};
	assign ey  = {cur_q.y[31], cur_q.y} - {last_y_q[31], last_y_q};
	assign adx = dx[32] ? 32'(-dx) : dx[31:0];
	assign ady = dy[32] ? 32'(-dy) : dy[31:0];
	assign aex = ex[32] ? 32'(-ex) : ex[31:0];
	assign aey = ey[32] ? 32'(-ey) : ey[31:0];

	// step count from the divider: ceil of the remaining length
	assign n_cnt    = {1'b0, div_rsp.quot} + {33'd0, (div_rsp.rem != '0)};
	assign n_over   = (n_cnt > 34'(MAX_PER_SEGMENT));
	assign seg_last = ((cnt_q + 1'b1) == lim_q);

	// interpolated point, rounded toward the segment start
	assign pt_x = dx[32] ? cur_q.px - qx_q : cur_q.px + qx_q;
	assign pt_y = dy[32] ? cur_q.py - qy_q : cur_q.py + qy_q;

	assign emit_ok = !hold_v_q || !out_full;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (!q_empty) state_d = q_dout.first ? ST_FIRST : ST_SQX;
			ST_FIRST: if (emit_ok) state_d = ST_FLUSH;
			ST_SQX:   state_d = ST_SQY;
			ST_SQY:   state_d = ST_SUM;
			ST_SUM:   state_d = ST_SQRT;
			ST_SQRT:  if (sqrt_rsp.done) state_d = ST_CMP;
			ST_CMP: begin
				if (pos_q >= len_q)
					state_d = cur_q.fin ? ST_FX : ST_FLUSH;
				else
					state_d = ST_DIVN;
			end
			ST_DIVN:  if (div_rsp.done) state_d = ST_MULX;
			ST_MULX:  state_d = ST_DXS;
			ST_DXS:   state_d = ST_DIVX;
			ST_DIVX:  if (div_rsp.done) state_d = ST_MULY;
			ST_MULY:  state_d = ST_DYS;
			ST_DYS:   state_d = ST_DIVY;
			ST_DIVY:  if (div_rsp.done) state_d = ST_EMIT;
			ST_EMIT: begin
				if (emit_ok)
					state_d = !seg_last ? ST_MULX : (cur_q.fin ? ST_FX : ST_FLUSH);
			end
			ST_FX:    state_d = ST_FY;
			ST_FY:    state_d = ST_FT;
			ST_FT:    state_d = ST_FC;
			ST_FC: begin
				if (acc_q < {1'b0, mul_q})
					state_d = ST_FLUSH;
				else if (emit_ok)
					state_d = ST_FLUSH;
			end
			ST_FLUSH: if (!hold_v_q || !out_full) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// outputs of each state
	always_comb begin
		q_pop          = 1'b0;
		mul_en         = 1'b0;
		mul_a          = '0;
		mul_b          = '0;
		sqrt_req.start = 1'b0;
		sqrt_req.rad   = acc_q + {1'b0, mul_q};
		div_req.start  = 1'b0;
		div_req.num_hi = {1'b0, mul_q[64:33]};
		div_req.num_lo = mul_q[32:0];
		div_req.den    = len_q;
		emit_req       = 1'b0;
		emit_x         = cur_q.x;
		emit_y         = cur_q.y;
		emit_tr        = 1'b0;
		case (state_q)
			ST_IDLE:  q_pop = !q_empty;
			ST_FIRST: emit_req = 1'b1;
			ST_SQX: begin
				mul_en = 1'b1;
				mul_a  = {1'b0, adx};
				mul_b  = adx;
			end
			ST_SQY: begin
				mul_en = 1'b1;
				mul_a  = {1'b0, ady};
				mul_b  = ady;
			end
			ST_SUM:   sqrt_req.start = 1'b1;
			ST_CMP: begin
				div_req.start  = (pos_q < len_q);
				div_req.num_hi = '0;
				div_req.num_lo = len_q - pos_q;
				div_req.den    = {2'b00, step_eff};
			end
			ST_MULX: begin
				mul_en = 1'b1;
				mul_a  = p_q;
				mul_b  = adx;
			end
			ST_DXS:   div_req.start = 1'b1;
			ST_MULY: begin
				mul_en = 1'b1;
				mul_a  = p_q;
				mul_b  = ady;
			end
			ST_DYS:   div_req.start = 1'b1;
			ST_EMIT: begin
				emit_req = 1'b1;
				emit_x   = pt_x;
				emit_y   = pt_y;
				emit_tr  = trunc_q;
			end
			ST_FX: begin
				mul_en = 1'b1;
				mul_a  = {1'b0, aex};
				mul_b  = aex;
			end
			ST_FY: begin
				mul_en = 1'b1;
				mul_a  = {1'b0, aey};
				mul_b  = aey;
			end
			ST_FT: begin
				mul_en = 1'b1;
				mul_a  = {17'd0, dup_threshold};
				mul_b  = {16'd0, dup_threshold};
			end
			ST_FC:    emit_req = (acc_q >= {1'b0, mul_q});
			default: ;
		endcase
	end

	// hold register: a result goes out once the next one or the end is known
	always_comb begin
		out_push = 1'b0;
		out_din  = hold_q;
		if (state_q == ST_FLUSH) begin
			out_push        = hold_v_q && !out_full;
			out_din.run_end = 1'b1;
		end else if (emit_req && emit_ok) begin
			out_push        = hold_v_q;
			out_din.run_end = 1'b0;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			hold_v_q <= 1'b0;
			pos_q    <= '0;
			last_x_q <= '0;
			last_y_q <= '0;
		end else begin
			state_q <= state_d;
			if (emit_req && emit_ok) begin
				hold_v_q <= 1'b1;
				last_x_q <= emit_x;
				last_y_q <= emit_y;
			end else if (state_q == ST_FLUSH && !out_full) begin
				hold_v_q <= 1'b0;
			end
			// path position carried between segments
			case (state_q)
				ST_FIRST: if (emit_ok) pos_q <= {2'b00, step_eff};
				ST_CMP:   if (pos_q >= len_q) pos_q <= pos_q - len_q;
				ST_EMIT:  if (emit_ok && seg_last) pos_q <= posn_q;
				default: ;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (q_pop)
			cur_q <= q_dout;
		if (mul_en)
			mul_q <= 65'(mul_a) * 65'(mul_b);
		if (emit_req && emit_ok) begin
			hold_q.x     <= emit_x;
			hold_q.y     <= emit_y;
			hold_q.trunc <= emit_tr;
		end
		hold_q.run_end <= 1'b0;
		case (state_q)
			ST_SQY:  acc_q <= {1'b0, mul_q};
			ST_FY:   acc_q <= {1'b0, mul_q};
			ST_FT:   acc_q <= acc_q + {1'b0, mul_q};
			ST_SQRT: if (sqrt_rsp.done) len_q <= sqrt_rsp.root;
			ST_CMP: begin
				p_q   <= pos_q;
				cnt_q <= '0;
			end
			ST_DIVN: begin
				if (div_rsp.done) begin
					trunc_q <= n_over;
					lim_q   <= n_over ? CW'(MAX_PER_SEGMENT) : n_cnt[CW-1:0];
					posn_q  <= (div_rsp.rem == '0) ? 33'd0
						: {2'b00, step_eff} - div_rsp.rem;
				end
			end
			ST_DIVX: if (div_rsp.done) qx_q <= div_rsp.quot[31:0];
			ST_DIVY: if (div_rsp.done) qy_q <= div_rsp.quot[31:0];
			ST_EMIT: begin
				if (emit_ok) begin
					cnt_q <= cnt_q + 1'b1;
					p_q   <= p_q + {2'b00, step_eff};
				end
			end
			default: ;
		endcase
	end

endmodule

### rtl/polyline_step_resampler.sv
// Polyline step resampler: vertices in, one per request, points spaced
// step_length apart along the path out, all signed Q16.16. A later vertex
// runs the square root unit for its segment length, then the divider for
// the step count when the segment holds points, then two divider passes
// per emitted point, then a duplicate test on a final vertex, and a last
// step closes out its last result. A full result queue adds stalls on top.
// Vertices queue ahead of the back end and results queue behind it, so
// both sides can stall independently.
`include "polyline_step_resampler_defines.svh"

module polyline_step_resampler #(
	parameter int MAX_PER_SEGMENT = psr_pkg::MAX_PER_SEGMENT_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [psr_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	input  logic                       push,
	output logic                       full,
	input  logic signed [31:0]         vertex_x,
	input  logic signed [31:0]         vertex_y,
	input  logic                       final_vertex,
	output logic                       empty,
	input  logic                       pop,
	output logic signed [31:0]         point_x,
	output logic signed [31:0]         point_y,
	output logic                       run_end,
	output logic                       truncated
);
	import psr_pkg::*;

	logic [STEP_W-1:0] step_q;
	logic [THR_W-1:0]  thr_q;
	logic              mid_push, mid_pop, mid_full, mid_empty;
	vtx_t              mid_din, mid_dout;
	logic              out_push, out_full;
	res_t              out_din, out_dout;
	sqrt_req_t         sqrt_req;
	sqrt_rsp_t         sqrt_rsp;
	div_req_t          div_req;
	div_rsp_t          div_rsp;
	logic              cfg_wr;

	// register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_RESET;
			thr_q  <= THR_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_STEP_LENGTH:   step_q <= pwdata[STEP_W-1:0];
				REG_DUP_THRESHOLD: thr_q  <= pwdata[THR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_STEP_LENGTH:   prdata = {1'b0, step_q};
			REG_DUP_THRESHOLD: prdata = {16'd0, thr_q};
			default:           prdata = '0;
		endcase
	end

	// front end
	psr_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.vertex_x     (vertex_x),
		.vertex_y     (vertex_y),
		.final_vertex (final_vertex),
		.q_push       (mid_push),
		.q_din        (mid_din),
		.q_full       (mid_full)
	);

	// request queue between front and back
	psr_fifo #(.WIDTH($bits(vtx_t)), .DEPTH(2)) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.din    (mid_din),
		.pop    (mid_pop),
		.dout   (mid_dout),
		.full   (mid_full),
		.empty  (mid_empty)
	);

	// back end and its arithmetic units
	psr_back #(.MAX_PER_SEGMENT(MAX_PER_SEGMENT)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.step_length   (step_q),
		.dup_threshold (thr_q),
		.q_empty       (mid_empty),
		.q_dout        (mid_dout),
		.q_pop         (mid_pop),
		.sqrt_req      (sqrt_req),
		.sqrt_rsp      (sqrt_rsp),
		.div_req       (div_req),
		.div_rsp       (div_rsp),
		.out_push      (out_push),
		.out_din       (out_din),
		.out_full      (out_full)
	);

	psr_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sqrt_req),
		.rsp    (sqrt_rsp)
	);

	psr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// result queue
	psr_fifo #(.WIDTH($bits(res_t)), .DEPTH(2)) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.din    (out_din),
		.pop    (pop),
		.dout   (out_dout),
		.full   (out_full),
		.empty  (empty)
	);

	assign point_x   = out_dout.x;
	assign point_y   = out_dout.y;
	assign run_end   = out_dout.run_end;
	assign truncated = out_dout.trunc;

	// checks
	`PSR_ASSERT_NOW(a_div_start_idle, div_req.start, !div_rsp.busy)
	`PSR_ASSERT_NOW(a_sqrt_start_idle, sqrt_req.start, !sqrt_rsp.busy)
	`PSR_ASSERT_NOW(a_out_no_overflow, out_push, !out_full)
	`PSR_ASSERT_NEXT(a_div_done_once, div_rsp.done, !div_rsp.done)

endmodule
